>>> rtl/core/wbtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wbtm_pkg;

    localparam int CLIENT_COUNT = 3;

    localparam logic [31:0] BUDGET0_RESET = 32'd100000000;
    localparam logic [31:0] BUDGET1_RESET = 32'd1000000;
    localparam logic [31:0] BUDGET2_RESET = 32'd100000000;
    localparam logic [31:0] WINDOW_RESET  = 32'd10000;

    typedef logic [1:0] client_t;

    typedef enum logic [1:0] {
        CMD_TRANSMIT = 2'd0,
        CMD_RETURN   = 2'd1,
        CMD_TIMEOUT  = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_FORWARD   = 3'd0,
        ACT_REJECT    = 3'd1,
        ACT_HOLD      = 3'd2,
        ACT_FREE      = 3'd3,
        ACT_NO_REGION = 3'd4,
        ACT_TIMEOUT   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        REG_BUDGET0 = 3'd0,
        REG_BUDGET1 = 3'd1,
        REG_BUDGET2 = 3'd2,
        REG_BASE0   = 3'd3,
        REG_BASE1   = 3'd4,
        REG_BASE2   = 3'd5,
        REG_WINDOW  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [CLIENT_COUNT-1:0][31:0] budget;
        logic [CLIENT_COUNT-1:0][47:0] region_base;
        logic [31:0]                   window_length;
    } cfg_t;

    typedef struct packed {
        logic [47:0] window_start;
        logic [31:0] bits_used;
        logic        timer_pending;
    } client_state_t;

    typedef struct packed {
        logic          wr_en;
        client_t       client;
        client_state_t state;
    } state_upd_t;

    typedef struct packed {
        cmd_t        command;
        client_t     client_id;
        logic [31:0] buf_offset;
        logic [15:0] buf_length;
        logic [47:0] phys_in;
        logic [47:0] now_time;
        logic        driver_full;
    } item_t;

    typedef struct packed {
        action_t     action;
        client_t     client_out;
        logic [47:0] phys_out;
        logic [31:0] offset_out;
        logic [15:0] length_out;
        logic        start_timer;
        logic [31:0] timer_delay;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/windowed_bandwidth_tx_mux.sv
// A word is captured on acceptance, evaluated from the input register, and its
// result is registered on advance. Throughput: one word per cycle unless the
// output stalls; per-client state is read, updated and written back in the
// evaluation cycle, so consecutive words see each other's effect.
// Reset (aresetn low, synchronous) empties both stages, clears all client state
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module windowed_bandwidth_tx_mux
    import wbtm_pkg::*;
#(
    parameter int BUFFER_COUNT = 512,
    parameter int BUFFER_BYTES = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [1:0]  s_client_id,
    input  wire logic [31:0] s_buf_offset,
    input  wire logic [15:0] s_buf_length,
    input  wire logic [47:0] s_phys_in,
    input  wire logic [47:0] s_now_time,
    input  wire logic        s_driver_full,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_action,
    output logic [1:0]       m_client_out,
    output logic [47:0]      m_phys_out,
    output logic [31:0]      m_offset_out,
    output logic [15:0]      m_length_out,
    output logic             m_start_timer,
    output logic [31:0]      m_timer_delay
);

    localparam logic [32:0] SPAN = 33'(BUFFER_BYTES) * 33'(BUFFER_COUNT);

    cfg_t cfg;

    item_t   item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    client_state_t [CLIENT_COUNT-1:0] state_reg;
    client_state_t [CLIENT_COUNT-1:0] state_next;

    result_t    eval_res;
    logic       eval_has_result;
    state_upd_t eval_upd;
    logic       advance;
    logic       accept;

    wbtm_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wbtm_eval #(
        .BUFFER_COUNT (BUFFER_COUNT),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_eval (
        .item       (item_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .res        (eval_res),
        .has_result (eval_has_result),
        .upd        (eval_upd)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = eval_has_result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        state_next = state_reg;
        if (advance && eval_upd.wr_en) begin
            for (int i = 0; i < CLIENT_COUNT; i++) begin
                if (eval_upd.client == client_t'(i)) begin
                    state_next[i] = eval_upd.state;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.command     <= cmd_t'(s_command);
            item_reg.client_id   <= s_client_id;
            item_reg.buf_offset  <= s_buf_offset;
            item_reg.buf_length  <= s_buf_length;
            item_reg.phys_in     <= s_phys_in;
            item_reg.now_time    <= s_now_time;
            item_reg.driver_full <= s_driver_full;
        end
        if (advance) begin
            res_reg <= eval_res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_action      = res_reg.action;
    assign m_client_out  = res_reg.client_out;
    assign m_phys_out    = res_reg.phys_out;
    assign m_offset_out  = res_reg.offset_out;
    assign m_length_out  = res_reg.length_out;
    assign m_start_timer = res_reg.start_timer;
    assign m_timer_delay = res_reg.timer_delay;

    a_timer_only_on_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_start_timer) |-> (m_action == ACT_HOLD))
        else $error("Timer request on a word that was not held.");

    a_timer_marks_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && eval_res.start_timer && item_reg.client_id != 2'd3)
            |=> state_reg[$past(item_reg.client_id)].timer_pending)
        else $error("Timer was requested but the client is not marked pending.");

    a_forward_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == ACT_FORWARD) |-> ({1'b0, m_offset_out} < SPAN))
        else $error("Forwarded word carries an offset outside the buffer region.");

    a_full_pipe_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("Input accepted while both stages are full and stalled.");

endmodule

`default_nettype wire

>>> rtl/core/wbtm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module wbtm_cfg_regs
    import wbtm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_BUDGET0: cfg_next.budget[0]      = cfg_data[31:0];
                REG_BUDGET1: cfg_next.budget[1]      = cfg_data[31:0];
                REG_BUDGET2: cfg_next.budget[2]      = cfg_data[31:0];
                REG_BASE0:   cfg_next.region_base[0] = cfg_data;
                REG_BASE1:   cfg_next.region_base[1] = cfg_data;
                REG_BASE2:   cfg_next.region_base[2] = cfg_data;
                REG_WINDOW:  cfg_next.window_length  = cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.budget[0]      <= BUDGET0_RESET;
            cfg_reg.budget[1]      <= BUDGET1_RESET;
            cfg_reg.budget[2]      <= BUDGET2_RESET;
            cfg_reg.region_base    <= '0;
            cfg_reg.window_length  <= WINDOW_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/wbtm_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module wbtm_eval
    import wbtm_pkg::*;
#(
    parameter int BUFFER_COUNT = 512,
    parameter int BUFFER_BYTES = 2048
) (
    input  wire item_t                         item,
    input  wire cfg_t                          cfg,
    input  wire client_state_t [CLIENT_COUNT-1:0] state,
    output result_t                            res,
    output logic                               has_result,
    output state_upd_t                         upd
);

    // Divisibility by the buffer size is tested as a power-of-two part and an
    // odd part; the odd part uses a multiply by its inverse modulo 2^32.
    function automatic int trailing_zeros(input int value);
        int count;
        count = 0;
        for (int i = 0; i < 17; i++) begin
            if (count == i && value[i] == 1'b0) begin
                count = i + 1;
            end
        end
        return count;
    endfunction

    function automatic logic [31:0] inverse32(input logic [31:0] odd);
        logic [31:0] x;
        x = odd;
        for (int i = 0; i < 5; i++) begin
            x = x * (32'd2 - odd * x);
        end
        return x;
    endfunction

    localparam int          ALIGN_SHIFT = trailing_zeros(BUFFER_BYTES);
    localparam logic [31:0] ODD_PART    = 32'(BUFFER_BYTES) >> ALIGN_SHIFT;
    localparam logic [31:0] ODD_INV     = inverse32(ODD_PART);
    localparam logic [31:0] ODD_LIMIT   = 32'hFFFF_FFFF / ODD_PART;
    localparam logic [31:0] LOW_MASK    = (32'd1 << ALIGN_SHIFT) - 32'd1;
    localparam logic [32:0] SPAN        = 33'(BUFFER_BYTES) * 33'(BUFFER_COUNT);

    client_state_t cur;
    logic [47:0]   elapsed;
    logic          expired;
    logic [47:0]   start_eff;
    logic [31:0]   used_eff;
    logic [31:0]   elapsed_eff;
    logic          over_budget;
    logic [31:0]   odd_product;
    logic          aligned;
    logic          in_range;
    logic [32:0]   charged;
    logic [CLIENT_COUNT-1:0] region_hit;
    logic          found;

    always_comb begin
        unique case (item.client_id)
            2'd1:    cur = state[1];
            2'd2:    cur = state[2];
            default: cur = state[0];
        endcase
    end

    assign elapsed     = item.now_time - cur.window_start;
    assign expired     = elapsed >= {16'd0, cfg.window_length};
    assign start_eff   = expired ? item.now_time : cur.window_start;
    assign used_eff    = expired ? 32'd0 : cur.bits_used;
    assign elapsed_eff = expired ? 32'd0 : elapsed[31:0];
    assign over_budget = (used_eff >= cfg.budget[item.client_id]) || item.driver_full;

    assign odd_product = (item.buf_offset >> ALIGN_SHIFT) * ODD_INV;
    assign aligned     = ((item.buf_offset & LOW_MASK) == 32'd0) && (odd_product <= ODD_LIMIT);
    assign in_range    = {1'b0, item.buf_offset} < SPAN;
    assign charged     = {1'b0, used_eff} + {14'd0, item.buf_length, 3'b000};

    always_comb begin
        for (int i = 0; i < CLIENT_COUNT; i++) begin
            region_hit[i] = (item.phys_in >= cfg.region_base[i]) &&
                ({1'b0, item.phys_in} < ({1'b0, cfg.region_base[i]} + {16'd0, SPAN}));
        end
    end

    always_comb begin
        res        = '0;
        has_result = 1'b1;
        upd        = '0;
        found      = 1'b0;
        res.client_out = item.client_id;
        unique case (item.command)
            CMD_TRANSMIT: begin
                res.offset_out = item.buf_offset;
                res.length_out = item.buf_length;
                res.action     = ACT_REJECT;
                if (item.client_id != 2'd3) begin
                    upd.wr_en              = 1'b1;
                    upd.client             = item.client_id;
                    upd.state.window_start = start_eff;
                    upd.state.bits_used    = used_eff;
                    upd.state.timer_pending = cur.timer_pending;
                    if (over_budget) begin
                        res.action = ACT_HOLD;
                        if (!cur.timer_pending) begin
                            res.start_timer         = 1'b1;
                            res.timer_delay         = cfg.window_length - elapsed_eff;
                            upd.state.timer_pending = 1'b1;
                        end
                    end else if (aligned && in_range) begin
                        res.action   = ACT_FORWARD;
                        res.phys_out = cfg.region_base[item.client_id]
                                       + {16'd0, item.buf_offset};
                        upd.state.bits_used = charged[32] ? 32'hFFFF_FFFF : charged[31:0];
                    end
                end
            end
            CMD_RETURN: begin
                res.length_out = item.buf_length;
                res.client_out = 2'd0;
                res.action     = ACT_NO_REGION;
                for (int i = 0; i < CLIENT_COUNT; i++) begin
                    if (!found && region_hit[i]) begin
                        found          = 1'b1;
                        res.action     = ACT_FREE;
                        res.client_out = client_t'(i);
                        res.offset_out = 32'(item.phys_in - cfg.region_base[i]);
                    end
                end
            end
            CMD_TIMEOUT: begin
                res.action = ACT_TIMEOUT;
                if (item.client_id != 2'd3) begin
                    upd.wr_en               = 1'b1;
                    upd.client              = item.client_id;
                    upd.state               = cur;
                    upd.state.timer_pending = 1'b0;
                end
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> verif/windowed_bandwidth_tx_mux_tb.sv
`timescale 1ns / 1ps

module windowed_bandwidth_tx_mux_tb;
    import wbtm_pkg::*;

    localparam int unsigned BUF_COUNT = 512;
    localparam int unsigned BUF_BYTES = 2048;
    localparam longint unsigned REGION_SPAN = longint'(BUF_BYTES) * BUF_COUNT;
    localparam logic [31:0] LAST_SLOT = (BUF_COUNT - 1) * BUF_BYTES;
    localparam client_t STRAY_CLIENT = client_t'(CLIENT_COUNT);
    localparam int STALL_LIMIT = 4000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;
    typedef enum {TX_STREAM, TX_BURSTY} tx_pace_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [1:0]  s_client_id = '0;
    logic [31:0] s_buf_offset = '0;
    logic [15:0] s_buf_length = '0;
    logic [47:0] s_phys_in = '0;
    logic [47:0] s_now_time = '0;
    logic        s_driver_full = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_action;
    logic [1:0]  m_client_out;
    logic [47:0] m_phys_out;
    logic [31:0] m_offset_out;
    logic [15:0] m_length_out;
    logic        m_start_timer;
    logic [31:0] m_timer_delay;

    // Shadow of the configuration and the per-client accounting state.
    logic [31:0] budget [CLIENT_COUNT];
    logic [47:0] region_base [CLIENT_COUNT];
    logic [31:0] win_len;
    logic [47:0] win_start [CLIENT_COUNT];
    logic [31:0] bits_spent [CLIENT_COUNT];
    bit          timer_armed [CLIENT_COUNT];

    result_t routing_due[$];
    int      routing_errors = 0;
    int      stall_cycles = 0;

    rx_mode_t    rx_mode = RX_ALWAYS;
    tx_pace_t    tx_pace = TX_STREAM;
    int          hold_token = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int unsigned rx_tick = 0;
    int unsigned burst_left = 0;
    int unsigned tx_share = 65;
    int unsigned time_step = 100;
    logic [47:0] stamp_now = '0;

    windowed_bandwidth_tx_mux dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_client_id   (s_client_id),
        .s_buf_offset  (s_buf_offset),
        .s_buf_length  (s_buf_length),
        .s_phys_in     (s_phys_in),
        .s_now_time    (s_now_time),
        .s_driver_full (s_driver_full),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_client_out  (m_client_out),
        .m_phys_out    (m_phys_out),
        .m_offset_out  (m_offset_out),
        .m_length_out  (m_length_out),
        .m_start_timer (m_start_timer),
        .m_timer_delay (m_timer_delay)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic bit route_descriptor(input item_t w, output result_t r);
        logic [47:0] elapsed;
        logic [63:0] spent;
        logic [63:0] phys;
        bit          found;
        int          c;
        r = '0;
        case (w.command)
            CMD_TRANSMIT: begin
                r.client_out = w.client_id;
                r.offset_out = w.buf_offset;
                r.length_out = w.buf_length;
                if (w.client_id >= CLIENT_COUNT) begin
                    r.action = ACT_REJECT;
                    return 1'b1;
                end
                c = w.client_id;
                elapsed = w.now_time - win_start[c];
                if (elapsed >= {16'd0, win_len}) begin
                    bits_spent[c] = '0;
                    win_start[c] = w.now_time;
                    elapsed = '0;
                end
                if (bits_spent[c] >= budget[c] || w.driver_full) begin
                    r.action = ACT_HOLD;
                    if (!timer_armed[c]) begin
                        r.start_timer = 1'b1;
                        r.timer_delay = win_len - elapsed[31:0];
                        timer_armed[c] = 1'b1;
                    end
                end else if (w.buf_offset % BUF_BYTES != 0
                             || {32'd0, w.buf_offset} >= REGION_SPAN) begin
                    r.action = ACT_REJECT;
                end else begin
                    r.action = ACT_FORWARD;
                    r.phys_out = region_base[c] + {16'd0, w.buf_offset};
                    spent = {32'd0, bits_spent[c]} + ({48'd0, w.buf_length} << 3);
                    bits_spent[c] = (spent > 64'hFFFF_FFFF) ? '1 : spent[31:0];
                end
            end
            CMD_RETURN: begin
                r.length_out = w.buf_length;
                r.action = ACT_NO_REGION;
                phys = {16'd0, w.phys_in};
                found = 1'b0;
                for (c = 0; c < CLIENT_COUNT && !found; c++) begin
                    if (phys >= {16'd0, region_base[c]}
                        && phys < {16'd0, region_base[c]} + REGION_SPAN) begin
                        found = 1'b1;
                        r.action = ACT_FREE;
                        r.client_out = client_t'(c);
                        r.offset_out = w.phys_in[31:0] - region_base[c][31:0];
                    end
                end
            end
            CMD_TIMEOUT: begin
                r.action = ACT_TIMEOUT;
                r.client_out = w.client_id;
                if (w.client_id < CLIENT_COUNT) begin
                    timer_armed[w.client_id] = 1'b0;
                end
            end
            default: begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic logic [47:0] rand48();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom();
        lo = $urandom();
        return {hi[15:0], lo};
    endfunction

    function automatic item_t word_of(input cmd_t cmd, input client_t c,
                                      input logic [31:0] off, input logic [15:0] len,
                                      input logic [47:0] phys, input logic [47:0] now,
                                      input logic full);
        item_t w;
        w.command = cmd;
        w.client_id = c;
        w.buf_offset = off;
        w.buf_length = len;
        w.phys_in = phys;
        w.now_time = now;
        w.driver_full = full;
        return w;
    endfunction

    function automatic item_t random_word();
        item_t       w;
        int unsigned pick;
        int unsigned c;
        pick = $urandom_range(0, 99);
        if (pick < tx_share) begin
            w.command = CMD_TRANSMIT;
        end else begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                w.command = CMD_NONE;
            end else if (pick < 9) begin
                w.command = CMD_TIMEOUT;
            end else begin
                w.command = CMD_RETURN;
            end
        end
        w.client_id = ($urandom_range(0, 19) == 0) ? STRAY_CLIENT
                                                   : client_t'($urandom_range(0, CLIENT_COUNT - 1));
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            w.buf_offset = $urandom_range(0, BUF_COUNT - 1) * BUF_BYTES;
        end else if (pick == 6) begin
            w.buf_offset = 32'(REGION_SPAN + $urandom_range(0, 3) * BUF_BYTES);
        end else if (pick == 7) begin
            w.buf_offset = $urandom_range(0, BUF_COUNT - 1) * BUF_BYTES
                           + $urandom_range(1, BUF_BYTES - 1);
        end else begin
            w.buf_offset = $urandom();
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            w.buf_length = '0;
        end else if (pick == 1) begin
            w.buf_length = '1;
        end else if (pick < 6) begin
            w.buf_length = 16'($urandom());
        end else begin
            w.buf_length = 16'($urandom_range(0, 1500));
        end
        c = $urandom_range(0, CLIENT_COUNT - 1);
        pick = $urandom_range(0, 9);
        case (pick)
            0: w.phys_in = region_base[c] - 48'd1;
            1: w.phys_in = region_base[c] + 48'(REGION_SPAN) - 48'd1;
            2: w.phys_in = region_base[c] + 48'(REGION_SPAN);
            3: w.phys_in = rand48();
            default: w.phys_in = region_base[c]
                                 + 48'($urandom_range(0, 32'(REGION_SPAN - 1)));
        endcase
        if ($urandom_range(0, 24) == 0) begin
            stamp_now = rand48();
        end else begin
            stamp_now = stamp_now + 48'($urandom_range(0, time_step));
        end
        w.now_time = stamp_now;
        w.driver_full = ($urandom_range(0, 9) == 0);
        return w;
    endfunction

    task automatic send_word(input item_t w);
        int unsigned gap;
        if (tx_pace == TX_BURSTY) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 8);
                burst_left = $urandom_range(1, 16);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
        s_valid <= 1'b1;
        s_command <= w.command;
        s_client_id <= w.client_id;
        s_buf_offset <= w.buf_offset;
        s_buf_length <= w.buf_length;
        s_phys_in <= w.phys_in;
        s_now_time <= w.now_time;
        s_driver_full <= w.driver_full;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic run_traffic(input int count);
        repeat (count) send_word(random_word());
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (routing_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [47:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [31:0] b0, input logic [31:0] b1,
                               input logic [31:0] b2, input logic [47:0] r0,
                               input logic [47:0] r1, input logic [47:0] r2,
                               input logic [31:0] wl);
        budget[0] = b0;
        budget[1] = b1;
        budget[2] = b2;
        region_base[0] = r0;
        region_base[1] = r1;
        region_base[2] = r2;
        win_len = wl;
        put_reg(REG_BUDGET0, {16'd0, b0});
        put_reg(REG_BUDGET1, {16'd0, b1});
        put_reg(REG_BUDGET2, {16'd0, b2});
        put_reg(REG_BASE0, r0);
        put_reg(REG_BASE1, r1);
        put_reg(REG_BASE2, r2);
        put_reg(REG_WINDOW, {16'd0, wl});
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_directed();
        rx_mode = RX_ALWAYS;
        tx_pace = TX_STREAM;
        send_word(word_of(CMD_TRANSMIT, 2'd0, 32'd0, 16'd0, '0, 48'd0, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd0, LAST_SLOT, 16'hFFFF, '0, 48'd5, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd0, 32'(REGION_SPAN), 16'd64, '0, 48'd6, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd0, 32'd1, 16'd64, '0, 48'd7, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd0, '1, 16'hFFFF, '0, 48'd8, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd1, 32'd2048, 16'hFFFF, '0, 48'd10, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd1, 32'd4096, 16'hFFFF, '0, 48'd12, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd1, 32'd0, 16'd100, '0, 48'd20, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd1, 32'd0, 16'd100, '0, 48'd25, 1'b0));
        send_word(word_of(CMD_TIMEOUT, 2'd1, '0, '0, '0, 48'd26, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd1, 32'd0, 16'd100, '0, 48'd30, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd1, 32'd6144, 16'd100, '0, 48'd10010, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd2, 32'd0, 16'd1, '0, 48'd10020, 1'b1));
        send_word(word_of(CMD_TRANSMIT, STRAY_CLIENT, 32'd2048, 16'd9, '0, 48'd10021, 1'b0));
        send_word(word_of(CMD_TIMEOUT, STRAY_CLIENT, '0, '0, '0, 48'd10022, 1'b0));
        send_word(word_of(CMD_RETURN, 2'd0, '0, 16'd77, 48'd0, 48'd10023, 1'b0));
        send_word(word_of(CMD_RETURN, 2'd2, '0, 16'd5, 48'(REGION_SPAN - 1), 48'd10024, 1'b0));
        send_word(word_of(CMD_RETURN, 2'd1, '0, 16'd5, 48'(REGION_SPAN), 48'd10025, 1'b0));
        send_word(word_of(CMD_RETURN, 2'd0, '1, '1, '1, 48'd10026, 1'b1));
        send_word(word_of(CMD_NONE, 2'd2, 32'd4096, 16'd3, 48'd12, 48'd10027, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd0, 32'd8192, 16'd40, '0, '1, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd0, 32'd10240, 16'd40, '0, 48'd5, 1'b0));
        send_word(word_of(CMD_TIMEOUT, 2'd2, '0, '0, '0, 48'd10030, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd2, 32'd100, 16'd8, '0, 48'd10031, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd2, 32'd100, 16'd8, '0, 48'd10032, 1'b1));
        wait_idle();
    endtask

    task automatic test_budget_windows();
        load_config(32'd2000000, 32'd600000, 32'd4000000, 48'h0000_0040_0000,
                    48'h0000_0080_0000, 48'h0000_00C0_0000, 32'd5000);
        rx_mode = RX_RANDOM;
        tx_pace = TX_BURSTY;
        tx_share = 75;
        time_step = 150;
        stamp_now = 48'd100000;
        run_traffic(140);
        wait_idle();
    endtask

    task automatic test_region_lookup();
        logic [47:0] b0;
        logic [47:0] b1;
        logic [47:0] b2;
        b0 = 48'h0000_0010_0000;
        b1 = b0 + 48'(REGION_SPAN / 2);
        b2 = 48'hFFFF_FFFF_F000;
        load_config(32'd4000000, 32'd4000000, 32'd4000000, b0, b1, b2, 32'd20000);
        rx_mode = RX_PATTERN;
        tx_pace = TX_STREAM;
        send_word(word_of(CMD_RETURN, 2'd0, '0, 16'd1, b0, 48'd1, 1'b0));
        send_word(word_of(CMD_RETURN, 2'd0, '0, 16'd2, b1, 48'd2, 1'b0));
        send_word(word_of(CMD_RETURN, 2'd0, '0, 16'd3, b0 + 48'(REGION_SPAN), 48'd3, 1'b0));
        send_word(word_of(CMD_RETURN, 2'd0, '0, 16'd4, b1 + 48'(REGION_SPAN - 1), 48'd4, 1'b0));
        send_word(word_of(CMD_RETURN, 2'd0, '0, 16'd5, b1 + 48'(REGION_SPAN), 48'd5, 1'b0));
        send_word(word_of(CMD_RETURN, 2'd0, '0, 16'd6, b2, 48'd6, 1'b0));
        send_word(word_of(CMD_RETURN, 2'd0, '0, 16'd7, '1, 48'd7, 1'b0));
        send_word(word_of(CMD_RETURN, 2'd0, '0, 16'd8, b0 - 48'd1, 48'd8, 1'b0));
        send_word(word_of(CMD_TRANSMIT, 2'd2, LAST_SLOT, 16'd60, '0, 48'd9, 1'b0));
        tx_pace = TX_BURSTY;
        tx_share = 40;
        time_step = 300;
        stamp_now = 48'd50;
        run_traffic(120);
        wait_idle();
    endtask

    task automatic test_backpressure();
        load_config(32'd3000000, 32'd1500000, 32'd3000000, 48'h0000_1000_0000,
                    48'h0000_2000_0000, 48'h0000_3000_0000, 32'd8000);
        tx_pace = TX_STREAM;
        tx_share = 65;
        time_step = 120;
        rx_mode = RX_ALWAYS;
        hold_token++;
        run_traffic(60);
        // The sender stops here until every outstanding word has come back.
        wait_idle();
        rx_mode = RX_PATTERN;
        tx_pace = TX_BURSTY;
        run_traffic(60);
        wait_idle();
    endtask

    task automatic test_extremes();
        load_config(32'd0, '1, 32'd1, '1, 48'd0, 48'h8000_0000_0000, '1);
        rx_mode = RX_RANDOM;
        tx_pace = TX_BURSTY;
        tx_share = 60;
        time_step = 32'h0010_0000;
        stamp_now = 48'hFFFF_FFFF_0000;
        run_traffic(130);
        wait_idle();
    endtask

    task automatic test_zero_window();
        load_config(32'd900000, 32'd300000, 32'd0, 48'h0000_0000_1000,
                    48'h0000_0100_0000, 48'h0000_0200_0000, 32'd0);
        rx_mode = RX_ALWAYS;
        tx_pace = TX_BURSTY;
        tx_share = 70;
        time_step = 20;
        run_traffic(80);
        wait_idle();
    endtask

    task automatic test_mixed();
        int unsigned wl;
        wl = $urandom_range(1, 20000);
        load_config($urandom_range(0, 3000000), $urandom_range(0, 3000000),
                    $urandom_range(0, 3000000), rand48(), rand48(), rand48(), wl);
        rx_mode = RX_PATTERN;
        tx_pace = TX_BURSTY;
        tx_share = 65;
        time_step = wl / 8 + 1;
        run_traffic(140);
        wait_idle();
    endtask

    task automatic note_mismatch(input bit orphan, input result_t want, input result_t got);
        routing_errors++;
        if (routing_errors <= 10) begin
            if (orphan) begin
                $display("Unexpected word: action %0d client %0d phys %h",
                         got.action, got.client_out, got.phys_out);
            end else begin
                $display("Expected: action %0d client %0d phys %h off %h len %h tmr %0d dly %h",
                         want.action, want.client_out, want.phys_out, want.offset_out,
                         want.length_out, want.start_timer, want.timer_delay);
                $display("Actual:   action %0d client %0d phys %h off %h len %h tmr %0d dly %h",
                         got.action, got.client_out, got.phys_out, got.offset_out,
                         got.length_out, got.start_timer, got.timer_delay);
            end
        end
    endtask

    item_t   taken_word;
    result_t taken_result;
    result_t seen_result;
    result_t want_result;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            taken_word.command = cmd_t'(s_command);
            taken_word.client_id = s_client_id;
            taken_word.buf_offset = s_buf_offset;
            taken_word.buf_length = s_buf_length;
            taken_word.phys_in = s_phys_in;
            taken_word.now_time = s_now_time;
            taken_word.driver_full = s_driver_full;
            if (route_descriptor(taken_word, taken_result)) begin
                routing_due.push_back(taken_result);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_result.action = action_t'(m_action);
            seen_result.client_out = m_client_out;
            seen_result.phys_out = m_phys_out;
            seen_result.offset_out = m_offset_out;
            seen_result.length_out = m_length_out;
            seen_result.start_timer = m_start_timer;
            seen_result.timer_delay = m_timer_delay;
            if (routing_due.size() == 0) begin
                note_mismatch(1'b1, seen_result, seen_result);
            end else begin
                want_result = routing_due.pop_front();
                if (seen_result.action !== want_result.action
                    || seen_result.client_out !== want_result.client_out
                    || seen_result.phys_out !== want_result.phys_out
                    || seen_result.offset_out !== want_result.offset_out
                    || seen_result.length_out !== want_result.length_out
                    || seen_result.start_timer !== want_result.start_timer
                    || seen_result.timer_delay !== want_result.timer_delay) begin
                    note_mismatch(1'b0, want_result, seen_result);
                end
            end
        end
    end

    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= RX_HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                default:   m_ready <= ((rx_tick % 7) < 4);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < CLIENT_COUNT; i++) begin
            region_base[i] = '0;
            win_start[i] = '0;
            bits_spent[i] = '0;
            timer_armed[i] = 1'b0;
        end
        budget[0] = BUDGET0_RESET;
        budget[1] = BUDGET1_RESET;
        budget[2] = BUDGET2_RESET;
        win_len = WINDOW_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_budget_windows();
        test_region_lookup();
        test_backpressure();
        test_extremes();
        test_zero_window();
        test_mixed();
        repeat (10) @(posedge aclk);
        if (routing_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
